[design/tpp_pkg.sv]
package tpp_pkg;

  // bits of the ceiling-division dividend (tile length plus limit minus one)
  localparam int unsigned DIV_BITS = 17;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_BITS + 1);

  // controller to datapath
  typedef struct packed {
    logic start;     // latch tile header fields and launch the divider
    logic step;      // process one byte and load the output register
    logic use_held;  // step on the held first byte of the tile
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic tile_active;  // bytes remain in the current tile
    logic start_ok;     // incoming length and limit are both nonzero
    logic div_done;     // packet count is ready
    logic out_free;     // output register can take a beat this cycle
  } status_t;

endpackage

[design/tpp_if.sv]
interface tpp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [7:0]  tile_tag;
  logic [15:0] tile_length;

  modport source (output valid, output data_byte, output tile_tag, output tile_length,
                  input ready);
  modport sink (input valid, input data_byte, input tile_tag, input tile_length,
                output ready);
endinterface

interface tpp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       packet_end;
  logic       tile_end;
  logic [7:0] header_tile;
  logic [7:0] sequence_number;
  logic [7:0] packet_total;
  logic [7:0] payload_length;
  logic [7:0] payload_xor;

  modport source (output valid, output payload_byte, output packet_end, output tile_end,
                  output header_tile, output sequence_number, output packet_total,
                  output payload_length, output payload_xor, input ready);
  modport sink (input valid, input payload_byte, input packet_end, input tile_end,
                input header_tile, input sequence_number, input packet_total,
                input payload_length, input payload_xor, output ready);
endinterface

[design/tile_payload_packetizer.sv]
// tile payload packetizer: cuts each tile's byte stream into packets of at
// most max_payload bytes and tags every packet-closing beat with its header
//
// channels
//   in_i   : one beat per tile byte; tile_tag and tile_length are sampled
//            only on the first beat of a tile (tile_length 0 is dropped)
//   out_o  : one beat per tile byte; on a packet's last byte packet_end
//            is set and the header fields are valid, otherwise they read 0
//   cfg    : cfg_we_i writes max_payload, picked up at the next tile start
//
// throughput
//   bytes inside a tile: result registered, 1 beat per cycle while the
//   output register is free; first byte of a tile: the packet count comes
//   from a bit-serial restoring divider, one quotient bit at a time, and the
//   first result waits until it is done, with the input held off meanwhile
//
// reset clears the tile state and the output valid; max_payload returns to
// 255. a stalled receiver holds the output register, and the input is taken
// only when the output register is empty or being drained that cycle
module tile_payload_packetizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i,
  tpp_in_if.sink     in_i,
  tpp_out_if.source  out_o
);
  import tpp_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencing: tile start, divider wait, byte steps
  tpp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // counters, xor, divider and output register
  tpp_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_data_i        (cfg_data_i),
    .data_byte_i       (in_i.data_byte),
    .tile_tag_i        (in_i.tile_tag),
    .tile_length_i     (in_i.tile_length),
    .out_ready_i       (out_o.ready),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_valid_o       (out_o.valid),
    .payload_byte_o    (out_o.payload_byte),
    .packet_end_o      (out_o.packet_end),
    .tile_end_o        (out_o.tile_end),
    .header_tile_o     (out_o.header_tile),
    .sequence_number_o (out_o.sequence_number),
    .packet_total_o    (out_o.packet_total),
    .payload_length_o  (out_o.payload_length),
    .payload_xor_o     (out_o.payload_xor)
  );

endmodule

[design/tpp_ctrl.sv]
module tpp_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  tpp_pkg::status_t status_i,
  output tpp_pkg::cmd_t    cmd_o
);
  import tpp_pkg::*;

  localparam logic [0:0] StRun = 1'b0;
  localparam logic [0:0] StDiv = 1'b1;

  logic [0:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == StRun) && status_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    unique case (state_q)
      StRun: begin
        if (accept) begin
          if (status_i.tile_active) begin
            cmd_o.step = 1'b1;
          end else if (status_i.start_ok) begin
            cmd_o.start = 1'b1;
            state_d     = StDiv;
          end
        end
      end
      StDiv: begin
        if (status_i.div_done && status_i.out_free) begin
          cmd_o.step     = 1'b1;
          cmd_o.use_held = 1'b1;
          state_d        = StRun;
        end
      end
      default: state_d = StRun;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StRun;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[design/tpp_datapath.sv]
module tpp_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [7:0]       cfg_data_i,
  input  logic [7:0]       data_byte_i,
  input  logic [7:0]       tile_tag_i,
  input  logic [15:0]      tile_length_i,
  input  logic             out_ready_i,
  input  tpp_pkg::cmd_t    cmd_i,
  output tpp_pkg::status_t status_o,
  output logic             out_valid_o,
  output logic [7:0]       payload_byte_o,
  output logic             packet_end_o,
  output logic             tile_end_o,
  output logic [7:0]       header_tile_o,
  output logic [7:0]       sequence_number_o,
  output logic [7:0]       packet_total_o,
  output logic [7:0]       payload_length_o,
  output logic [7:0]       payload_xor_o
);
  import tpp_pkg::*;

  // configuration
  logic [7:0] max_payload_q;

  // tile state
  logic [15:0] left_q, left_d;
  logic [7:0]  bip_q, bip_d;
  logic [7:0]  idx_q, idx_d;
  logic [7:0]  xor_q, xor_d;
  logic [7:0]  tile_q, limit_q, held_q;

  // divider
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic [DIV_BITS-1:0]  div_quo_q;
  logic [7:0]           div_rem_q;
  logic [DIV_BITS-1:0]  dividend;
  logic [8:0]           div_shift;
  logic                 div_ge;

  // output register
  logic       out_valid_q;
  logic [7:0] o_byte_q, o_tile_q, o_seq_q, o_total_q, o_len_q, o_xor_q;
  logic       o_pend_q, o_tend_q;

  // one byte step
  logic [7:0]  b;
  logic [7:0]  xor_n, bip_n;
  logic [15:0] left_n;
  logic        last, closes;

  assign status_o.tile_active = (left_q != 16'd0);
  assign status_o.start_ok    = (tile_length_i != 16'd0) && (max_payload_q != 8'd0);
  assign status_o.div_done    = (div_cnt_q == '0);
  assign status_o.out_free    = !out_valid_q || out_ready_i;

  assign dividend  = {1'b0, tile_length_i} + DIV_BITS'(max_payload_q) - DIV_BITS'(1);
  assign div_shift = {div_rem_q, div_quo_q[DIV_BITS-1]};
  assign div_ge    = (div_shift >= {1'b0, limit_q});

  assign b      = cmd_i.use_held ? held_q : data_byte_i;
  assign xor_n  = xor_q ^ b;
  assign bip_n  = bip_q + 8'd1;
  assign left_n = left_q - 16'd1;
  assign last   = (left_n == 16'd0);
  assign closes = last || (bip_n >= limit_q);

  always_comb begin
    left_d = left_q;
    bip_d  = bip_q;
    idx_d  = idx_q;
    xor_d  = xor_q;
    if (cmd_i.start) begin
      left_d = tile_length_i;
      bip_d  = 8'd0;
      idx_d  = 8'd0;
      xor_d  = 8'd0;
    end else if (cmd_i.step) begin
      left_d = left_n;
      if (closes) begin
        bip_d = 8'd0;
        xor_d = 8'd0;
        idx_d = idx_q + 8'd1;
      end else begin
        bip_d = bip_n;
        xor_d = xor_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= 8'd255;
      left_q        <= '0;
      bip_q         <= '0;
      idx_q         <= '0;
      xor_q         <= '0;
      div_cnt_q     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_payload_q <= cfg_data_i;
      end
      left_q <= left_d;
      bip_q  <= bip_d;
      idx_q  <= idx_d;
      xor_q  <= xor_d;
      if (cmd_i.start) begin
        div_cnt_q <= DIV_CNT_W'(DIV_BITS);
      end else if (div_cnt_q != '0) begin
        div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
      end
      if (cmd_i.step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      tile_q    <= tile_tag_i;
      limit_q   <= max_payload_q;
      held_q    <= data_byte_i;
      div_quo_q <= dividend;
      div_rem_q <= '0;
    end else if (div_cnt_q != '0) begin
      div_rem_q <= div_ge ? 8'(div_shift - {1'b0, limit_q}) : div_shift[7:0];
      div_quo_q <= {div_quo_q[DIV_BITS-2:0], div_ge};
    end
    if (cmd_i.step) begin
      o_byte_q  <= b;
      o_pend_q  <= closes;
      o_tend_q  <= last;
      o_tile_q  <= closes ? tile_q : 8'd0;
      o_seq_q   <= closes ? idx_q : 8'd0;
      o_total_q <= closes ? div_quo_q[7:0] : 8'd0;
      o_len_q   <= closes ? bip_n : 8'd0;
      o_xor_q   <= closes ? xor_n : 8'd0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign payload_byte_o    = o_byte_q;
  assign packet_end_o      = o_pend_q;
  assign tile_end_o        = o_tend_q;
  assign header_tile_o     = o_tile_q;
  assign sequence_number_o = o_seq_q;
  assign packet_total_o    = o_total_q;
  assign payload_length_o  = o_len_q;
  assign payload_xor_o     = o_xor_q;

endmodule

[design/tpp_checker.sv]
module tpp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] payload_byte_i,
  input logic       packet_end_i,
  input logic       tile_end_i,
  input logic [7:0] header_tile_i,
  input logic [7:0] sequence_number_i,
  input logic [7:0] packet_total_i,
  input logic [7:0] payload_length_i,
  input logic [7:0] payload_xor_i
);

  // stalled beat holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(payload_byte_i)
      && $stable(packet_end_i) && $stable(payload_xor_i))
    else $error("stalled output beat changed");

  // tile end only closes a packet
  a_tile_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && tile_end_i |-> packet_end_i)
    else $error("tile_end without packet_end");

  // header fields are zero mid packet
  a_hdr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !packet_end_i |-> header_tile_i == 8'd0 && sequence_number_i == 8'd0
      && packet_total_i == 8'd0 && payload_length_i == 8'd0 && payload_xor_i == 8'd0)
    else $error("header fields set on a mid packet beat");

  // a closed packet holds at least one byte
  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && packet_end_i |-> payload_length_i != 8'd0)
    else $error("closed packet with zero length");

endmodule

bind tile_payload_packetizer tpp_checker u_tpp_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .payload_byte_i    (out_o.payload_byte),
  .packet_end_i      (out_o.packet_end),
  .tile_end_i        (out_o.tile_end),
  .header_tile_i     (out_o.header_tile),
  .sequence_number_i (out_o.sequence_number),
  .packet_total_i    (out_o.packet_total),
  .payload_length_i  (out_o.payload_length),
  .payload_xor_i     (out_o.payload_xor)
);

[sim/tile_payload_packetizer_test.sv]
`timescale 1ns / 100ps

module tile_payload_packetizer_test;

  localparam int unsigned DRAIN_CYCLES   = 24;   // margin for the late first beat of a tile
  localparam int unsigned RX_HOLD_CYCLES = 200;  // long receiver hold-off
  localparam int unsigned RANDOM_BYTES   = 400;

  // one output beat as the packetizer should present it
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       packet_end;
    logic       tile_end;
    logic [7:0] header_tile;
    logic [7:0] sequence_number;
    logic [7:0] packet_total;
    logic [7:0] payload_length;
    logic [7:0] payload_xor;
  } beat_t;

  logic       clk_i    = 1'b0;
  logic       rst_ni   = 1'b0;
  logic       cfg_we   = 1'b0;
  logic [7:0] cfg_data = 8'd0;

  tpp_in_if  in_if ();
  tpp_out_if out_if ();

  tile_payload_packetizer u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // packet model: own copy of the tile state and the payload limit register
  // ---------------------------------------------------------------------------
  logic [7:0]  limit_cfg  = 8'd255;  // max_payload as last written
  logic [15:0] tile_left  = '0;      // zero while waiting for a tile start
  logic [7:0]  pkt_fill   = '0;
  logic [7:0]  pkt_idx    = '0;
  logic [7:0]  pkt_cnt    = '0;
  logic [7:0]  pkt_xor    = '0;
  logic [7:0]  tile_id    = '0;
  logic [7:0]  pkt_limit  = '0;

  beat_t       beat_q[$];            // beats still owed by the block
  int unsigned mismatch_count = 0;

  // control knobs shared by the test tasks and the pacing processes
  logic        tx_idle_en  = 1'b1;
  logic        rx_idle_en  = 1'b1;
  logic        rx_hold_req = 1'b0;

  // advance the packet model by one accepted input beat
  function automatic void predict_beat(input logic [7:0] b, input logic [7:0] tag,
                                       input logic [15:0] len);
    beat_t       e;
    int unsigned cnt;
    logic        last;
    logic        closes;
    if (tile_left == 16'd0) begin
      // empty tile or zero limit: dropped, still waiting for a tile start
      if (len == 16'd0 || limit_cfg == 8'd0) return;
      cnt       = (int'(len) + int'(limit_cfg) - 1) / int'(limit_cfg);
      tile_left = len;
      pkt_limit = limit_cfg;
      pkt_cnt   = cnt[7:0];
      pkt_idx   = '0;
      pkt_fill  = '0;
      pkt_xor   = '0;
      tile_id   = tag;
    end
    pkt_xor   = pkt_xor ^ b;
    pkt_fill  = pkt_fill + 8'd1;
    tile_left = tile_left - 16'd1;
    last      = (tile_left == 16'd0);
    closes    = last || (pkt_fill >= pkt_limit);
    e = '0;
    e.payload_byte = b;
    if (closes) begin
      e.packet_end      = 1'b1;
      e.tile_end        = last;
      e.header_tile     = tile_id;
      e.sequence_number = pkt_idx;
      e.packet_total    = pkt_cnt;
      e.payload_length  = pkt_fill;
      e.payload_xor     = pkt_xor;
      pkt_idx  = pkt_idx + 8'd1;
      pkt_fill = '0;
      pkt_xor  = '0;
    end
    beat_q.insert(beat_q.size(), e);
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $realtime, name, want, got);
      mismatch_count++;
    end
  endfunction

  // input side: every beat taken by the block feeds the model
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready)
      predict_beat(in_if.data_byte, in_if.tile_tag, in_if.tile_length);
  end

  // output side: each beat taken from the block against the oldest prediction
  always @(posedge clk_i) begin : out_check
    beat_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (beat_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none actual byte %0h", $realtime,
                 out_if.payload_byte);
        mismatch_count++;
      end else begin
        e = beat_q.pop_front();
        check_field("payload_byte", e.payload_byte, out_if.payload_byte);
        check_field("packet_end", {7'd0, e.packet_end}, {7'd0, out_if.packet_end});
        check_field("tile_end", {7'd0, e.tile_end}, {7'd0, out_if.tile_end});
        check_field("header_tile", e.header_tile, out_if.header_tile);
        check_field("sequence_number", e.sequence_number, out_if.sequence_number);
        check_field("packet_total", e.packet_total, out_if.packet_total);
        check_field("payload_length", e.payload_length, out_if.payload_length);
        check_field("payload_xor", e.payload_xor, out_if.payload_xor);
      end
    end
  end

  // receiver pacing: bursts of ready and stalls, mostly short, a few long;
  // a hold request keeps ready low for a counted stretch
  initial begin : rx_pacing
    int unsigned r;
    int unsigned n;
    logic        v;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        out_if.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
        rx_hold_req = 1'b0;
        out_if.ready <= 1'b1;
      end else if (!rx_idle_en) begin
        out_if.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          v = 1'b1;
          n = $urandom_range(1, 8);
        end else if (r < 95) begin
          v = 1'b0;
          n = $urandom_range(1, 3);
        end else begin
          v = 1'b0;
          n = $urandom_range(20, 60);
        end
        out_if.ready <= v;
        repeat (n - 1) @(posedge clk_i);
      end
    end
  end

  // sender gap: mostly none, often a few cycles, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // offer one byte and wait until the block takes it; valid stays high on
  // return so a back-to-back byte never drops it in between
  task automatic send_byte(input logic [7:0] b, input logic [7:0] tag,
                           input logic [15:0] len);
    int unsigned gap;
    gap = tx_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.data_byte   <= b;
    in_if.tile_tag    <= tag;
    in_if.tile_length <= len;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // whole tile with random content; tag and length are noise after the first byte
  task automatic send_tile(input logic [7:0] tag, input logic [15:0] len);
    for (int unsigned i = 0; i < len; i++) begin
      if (i == 0) send_byte(8'($urandom), tag, len);
      else send_byte(8'($urandom), 8'($urandom), 16'($urandom));
    end
  endtask

  // drop valid, let every owed beat come out, then allow for a late first beat
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (beat_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_max_payload(input logic [7:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_data  <= v;
    limit_cfg = v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // directed tests
  // ---------------------------------------------------------------------------

  // limit 255 straight out of reset, extreme bytes and tags
  task automatic test_reset_defaults();
    send_byte(8'h00, 8'hFF, 16'd1);
    send_byte(8'hFF, 8'h00, 16'd3);
    send_byte(8'hFF, 8'h00, 16'hFFFF);
    send_byte(8'h00, 8'hFF, 16'h0000);
    wait_idle();
  endtask

  // every byte closes its own packet
  task automatic test_min_limit();
    write_max_payload(8'd1);
    send_tile(8'h81, 16'd4);
    wait_idle();
  endtask

  // zero-length tile start is swallowed, the next byte starts a real tile
  task automatic test_empty_tile();
    send_byte(8'h11, 8'h22, 16'd0);
    send_tile(8'h33, 16'd2);
    wait_idle();
  endtask

  // tile start under a zero limit is swallowed too
  task automatic test_zero_limit();
    write_max_payload(8'd0);
    send_byte(8'h44, 8'h55, 16'd5);
    write_max_payload(8'd3);
    send_tile(8'h66, 16'd4);
    wait_idle();
  endtask

  // a new limit written mid tile only applies from the next tile on
  task automatic test_limit_change_mid_tile();
    write_max_payload(8'd3);
    for (int unsigned i = 0; i < 7; i++) begin
      if (i == 2) write_max_payload(8'd2);
      if (i == 0) send_byte(8'($urandom), 8'h77, 16'd7);
      else send_byte(8'($urandom), 8'($urandom), 16'($urandom));
    end
    send_tile(8'h78, 16'd5);
    wait_idle();
  endtask

  // receiver holds off while the sender keeps offering: the block must fill
  // up and stall its input without losing a beat
  task automatic test_rx_backpressure();
    logic saved_tx;
    saved_tx = tx_idle_en;
    tx_idle_en = 1'b0;
    write_max_payload(8'd5);
    rx_hold_req = 1'b1;
    send_tile(8'h5A, 16'd60);
    wait_idle();
    while (rx_hold_req) @(posedge clk_i);
    tx_idle_en = saved_tx;
  endtask

  // 257 single-byte packets: the sequence number wraps and the packet total
  // reads 1
  task automatic test_sequence_wrap();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    write_max_payload(8'd1);
    send_tile(8'hC3, 16'd257);
    wait_idle();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // random tiles: mostly well-formed tiles with random content and limits,
  // some empty starts, zero limits and limit writes mid tile
  // ---------------------------------------------------------------------------
  task automatic test_random_tiles();
    int unsigned sent;
    int unsigned r;
    logic [15:0] len;
    logic        force_write;
    sent = 0;
    force_write = 1'b1;
    while (sent < RANDOM_BYTES) begin
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      if (force_write || $urandom_range(0, 2) == 0) begin
        r = $urandom_range(0, 99);
        if (r < 40) write_max_payload(8'($urandom_range(1, 4)));
        else if (r < 70) write_max_payload(8'($urandom_range(5, 16)));
        else if (r < 85) write_max_payload(8'($urandom_range(17, 254)));
        else if (r < 95) write_max_payload(8'd255);
        else write_max_payload(8'd0);
        force_write = 1'b0;
      end
      if (limit_cfg == 8'd0) begin
        // swallowed start, then make sure a usable limit follows
        send_byte(8'($urandom), 8'($urandom), 16'($urandom_range(1, 65535)));
        force_write = 1'b1;
        continue;
      end
      r = $urandom_range(0, 99);
      if (r < 10) len = 16'd0;
      else if (r < 75) len = 16'($urandom_range(1, 24));
      else if (r < 95) len = 16'($urandom_range(25, 120));
      else len = 16'($urandom_range(121, 400));
      if (len == 16'd0) begin
        send_byte(8'($urandom), 8'($urandom), 16'd0);
        continue;
      end
      for (int unsigned i = 0; i < len; i++) begin
        if (i > 0 && $urandom_range(0, 99) < 2)
          write_max_payload(8'($urandom_range(1, 255)));
        if (i == 0) send_byte(8'($urandom), 8'($urandom), len);
        else send_byte(8'($urandom), 8'($urandom), 16'($urandom));
      end
      sent += len;
    end
    wait_idle();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_if.valid       = 1'b0;
    in_if.data_byte   = 8'd0;
    in_if.tile_tag    = 8'd0;
    in_if.tile_length = 16'd0;
    out_if.ready      = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_min_limit();
    test_empty_tile();
    test_zero_limit();
    test_limit_change_mid_tile();
    test_rx_backpressure();
    test_sequence_wrap();
    test_random_tiles();

    // all stimulus taken, nothing owed, block quiet through the drain margin
    wait_idle();
    if (mismatch_count == 0) begin
      $display("[tile_payload_packetizer] OK");
    end else begin
      $display("[tile_payload_packetizer] ERROR");
    end
    $finish;
  end

  // watchdog well beyond the slowest legal run
  initial begin
    #10ms;
    $display("[tile_payload_packetizer] ERROR");
    $finish;
  end

endmodule

[filelist.f]
design/tpp_pkg.sv
design/tpp_if.sv
design/tpp_ctrl.sv
design/tpp_datapath.sv
design/tile_payload_packetizer.sv
design/tpp_checker.sv
sim/tile_payload_packetizer_test.sv
